@@ rtl/ilm_pkg.sv @@
package ilm_pkg;

  // Default sizing
  localparam int unsigned NODE_COUNT_DEF  = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Action codes; code 7 is unused and leaves the list alone
  typedef enum logic [2:0] {
    ACT_INS_AFTER  = 3'd0,
    ACT_INS_BEFORE = 3'd1,
    ACT_ERASE      = 3'd2,
    ACT_PUSH_FRONT = 3'd3,
    ACT_PUSH_BACK  = 3'd4,
    ACT_POP_FRONT  = 3'd5,
    ACT_POP_BACK   = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_BADHANDLE  = 2'd3
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;  // item taken, issue memory reads
    logic exec;    // decide, first write pass, load result
    logic link;    // second write pass
  } ilm_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register full and not being taken
  } ilm_stat_t;

endpackage

@@ rtl/indexed_linked_list_manager_core.sv @@
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_ready  action, handle, item_value
// out      out_valid/out_ready  status, node_handle, removed_value, entry_count
//
// An item passes accept (registered link, payload and in-use reads), update
// (decision, first link writes, result loaded), then link (second writes).
// Each link memory has one write port; an insert or removal writes up to two
// next and two prev links, which sets the rate. The result is valid after the
// update, which a waiting result holds; in_ready returns after the link step.
// Reset clears control only; never-used nodes sit below a low-water mark.
module indexed_linked_list_manager_core #(
  parameter int unsigned NODE_COUNT  = ilm_pkg::NODE_COUNT_DEF,
  parameter int unsigned VALUE_WIDTH = ilm_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [7:0]  handle,
  input  logic [31:0] item_value,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  node_handle,
  output logic [31:0] removed_value,
  output logic [7:0]  entry_count
);

  ilm_pkg::ilm_cmd_t  cmd;
  ilm_pkg::ilm_stat_t st;

  // Sequencer: idle -> update -> link
  ilm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Link memories, free list, sentinel links and result register
  ilm_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .action        (action),
    .handle        (handle),
    .item_value    (item_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .node_handle   (node_handle),
    .removed_value (removed_value),
    .entry_count   (entry_count)
  );

endmodule

@@ rtl/ilm_ctrl.sv @@
module ilm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilm_pkg::ilm_stat_t st,
  output ilm_pkg::ilm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LINK = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!st.out_busy) state_next = S_LINK;
      end
      S_LINK: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.exec   = (state == S_EXEC) && !st.out_busy;
  assign cmd.link   = (state == S_LINK);

`ifndef SYNTH
  a_link_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> $past(state == S_EXEC))
    else $error("link pass without update pass");
  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_EXEC))
    else $error("accepted item not processed");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");
`endif

endmodule

@@ rtl/ilm_datapath.sv @@
module ilm_datapath #(
  parameter int unsigned NODE_COUNT  = ilm_pkg::NODE_COUNT_DEF,
  parameter int unsigned VALUE_WIDTH = ilm_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ilm_pkg::ilm_cmd_t  cmd,
  output ilm_pkg::ilm_stat_t st,
  input  logic [2:0]         action,
  input  logic [7:0]         handle,
  input  logic [31:0]        item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [7:0]         node_handle,
  output logic [31:0]        removed_value,
  output logic [7:0]         entry_count
);

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);
  typedef logic [IDX_W-1:0] idx_t;

  // Link, payload and in-use memories
  idx_t                   next_mem [NODE_COUNT];
  idx_t                   prev_mem [NODE_COUNT];
  logic [VALUE_WIDTH-1:0] val_mem  [NODE_COUNT];
  logic                   use_mem  [NODE_COUNT];

  // Sentinel links, free list and count
  idx_t front;
  idx_t back;
  idx_t free_head;
  idx_t low_mark;   // nodes 1..low_mark were never taken from the pool
  idx_t count;

  // Item fields latched on accept
  ilm_pkg::action_t       act_q;
  idx_t                   tgt_q;
  logic                   hnd_ok_q;
  logic [VALUE_WIDTH-1:0] val_q;

  // Registered read data
  idx_t                   nx_rd_a;
  idx_t                   nx_rd_b;
  idx_t                   pv_rd;
  logic [VALUE_WIDTH-1:0] vl_rd;
  logic                   us_rd;

  // Second pass plan
  logic lk_ins;
  logic lk_rem;
  idx_t lk_node;
  idx_t lk_left;
  idx_t lk_right;
  idx_t lk_free;

  ilm_pkg::action_t act_in;
  idx_t             h_idx;
  logic             hnd_ok;
  idx_t             rd_addr;

  idx_t             tgt_next;
  idx_t             tgt_prev;
  logic             tgt_used;
  idx_t             left_sel;
  idx_t             right_sel;
  logic             do_ins;
  logic             do_rem;
  ilm_pkg::status_t status_c;
  idx_t             node_c;
  idx_t             free_after_take;

  logic nx_we;
  idx_t nx_wa;
  idx_t nx_wd;
  logic pv_we;
  idx_t pv_wa;
  idx_t pv_wd;
  logic us_we;
  idx_t us_wa;
  logic us_wd;
  logic vl_we;

  // Accept-side decode
  assign act_in = ilm_pkg::action_t'(action);
  assign h_idx  = IDX_W'(handle);
  assign hnd_ok = (32'(handle) < 32'(NODE_COUNT));

  always_comb begin
    unique case (act_in) inside
      ilm_pkg::ACT_INS_AFTER, ilm_pkg::ACT_INS_BEFORE, ilm_pkg::ACT_ERASE: rd_addr = h_idx;
      ilm_pkg::ACT_POP_FRONT: rd_addr = front;
      ilm_pkg::ACT_POP_BACK:  rd_addr = back;
      default:                rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q    <= act_in;
      tgt_q    <= rd_addr;
      hnd_ok_q <= hnd_ok;
      val_q    <= VALUE_WIDTH'(item_value);
    end
  end

  // Update decision
  assign tgt_next = (tgt_q == '0) ? front : nx_rd_a;
  assign tgt_prev = (tgt_q == '0) ? back  : pv_rd;
  assign tgt_used = us_rd && (tgt_q > low_mark);  // untouched nodes read as free
  assign free_after_take = (free_head == low_mark) ? idx_t'(free_head - 1'b1) : nx_rd_b;

  always_comb begin
    left_sel  = tgt_prev;
    right_sel = tgt_next;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    status_c  = ilm_pkg::ST_OK;
    unique case (act_q) inside
      ilm_pkg::ACT_INS_AFTER, ilm_pkg::ACT_INS_BEFORE: begin
        if (act_q == ilm_pkg::ACT_INS_AFTER) left_sel = tgt_q;
        else right_sel = tgt_q;
        if (!(hnd_ok_q && (tgt_q == '0 || tgt_used))) status_c = ilm_pkg::ST_BADHANDLE;
        else if (free_head == '0) status_c = ilm_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      ilm_pkg::ACT_PUSH_FRONT, ilm_pkg::ACT_PUSH_BACK: begin
        if (act_q == ilm_pkg::ACT_PUSH_FRONT) left_sel = tgt_q;
        else right_sel = tgt_q;
        if (free_head == '0) status_c = ilm_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      ilm_pkg::ACT_ERASE: begin
        if (!(hnd_ok_q && tgt_used)) status_c = ilm_pkg::ST_BADHANDLE;
        else do_rem = 1'b1;
      end
      ilm_pkg::ACT_POP_FRONT, ilm_pkg::ACT_POP_BACK: begin
        if (count == '0) status_c = ilm_pkg::ST_EMPTY;
        else do_rem = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign node_c = do_ins ? free_head : (do_rem ? tgt_q : '0);

  // Memory write ports: first pass on exec, second on link
  always_comb begin
    nx_we = 1'b0;  nx_wa = '0;  nx_wd = '0;
    pv_we = 1'b0;  pv_wa = '0;  pv_wd = '0;
    us_we = 1'b0;  us_wa = '0;  us_wd = 1'b0;
    vl_we = 1'b0;
    if (cmd.exec && do_ins) begin
      nx_we = 1'b1;  nx_wa = free_head;  nx_wd = right_sel;
      pv_we = 1'b1;  pv_wa = free_head;  pv_wd = left_sel;
      us_we = 1'b1;  us_wa = free_head;  us_wd = 1'b1;
      vl_we = 1'b1;
    end else if (cmd.exec && do_rem) begin
      nx_we = (left_sel != '0);   nx_wa = left_sel;   nx_wd = right_sel;
      pv_we = (right_sel != '0);  pv_wa = right_sel;  pv_wd = left_sel;
      us_we = 1'b1;  us_wa = tgt_q;  us_wd = 1'b0;
    end else if (cmd.link && lk_ins) begin
      nx_we = (lk_left != '0);   nx_wa = lk_left;   nx_wd = lk_node;
      pv_we = (lk_right != '0);  pv_wa = lk_right;  pv_wd = lk_node;
    end else if (cmd.link && lk_rem) begin
      nx_we = 1'b1;  nx_wa = lk_node;  nx_wd = lk_free;
      pv_we = 1'b1;  pv_wa = lk_node;  pv_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd.accept) begin
      nx_rd_a <= next_mem[rd_addr];
      nx_rd_b <= next_mem[free_head];
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (cmd.accept) pv_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vl_we) val_mem[free_head] <= val_q;
    if (cmd.accept) vl_rd <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (us_we) use_mem[us_wa] <= us_wd;
    if (cmd.accept) us_rd <= use_mem[rd_addr];
  end

  // List state
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      back      <= '0;
      free_head <= idx_t'(NODE_COUNT - 1);
      low_mark  <= idx_t'(NODE_COUNT - 1);
      count     <= '0;
      lk_ins    <= 1'b0;
      lk_rem    <= 1'b0;
    end else begin
      if (cmd.exec) begin
        lk_ins <= do_ins;
        lk_rem <= do_rem;
        if (do_ins) begin
          free_head <= free_after_take;
          if (free_head == low_mark) low_mark <= free_after_take;
          count <= count + 1'b1;
        end
        if (do_rem) begin
          if (left_sel == '0)  front <= right_sel;
          if (right_sel == '0) back  <= left_sel;
          free_head <= tgt_q;
          count     <= count - 1'b1;
        end
      end
      if (cmd.link && lk_ins) begin
        if (lk_left == '0)  front <= lk_node;
        if (lk_right == '0) back  <= lk_node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      lk_node  <= node_c;
      lk_left  <= left_sel;
      lk_right <= right_sel;
      lk_free  <= free_head;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status        <= status_c;
      node_handle   <= 8'(node_c);
      removed_value <= do_rem ? 32'(vl_rd) : 32'd0;
      if (do_ins)      entry_count <= 8'(idx_t'(count + 1'b1));
      else if (do_rem) entry_count <= 8'(idx_t'(count - 1'b1));
      else             entry_count <= 8'(count);
    end
  end

  assign st.out_busy = out_valid && !out_ready;

`ifndef SYNTH
  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= free_head)
    else $error("untouched region above free head");
  a_empty_links: assert property (@(posedge clk) disable iff (rst)
    !cmd.link |-> ((count == '0) == (front == '0)))
    else $error("sentinel front disagrees with count");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("result not presented after update");
`endif

endmodule
